>>> rtl/tiled_yuv_to_rgb_pixel_fetch_defines.svh
// ============================================================================
// Tiled YUV to RGB pixel fetch - assertion macros
// Shared property wrappers; each expects i_clk and i_rst_n in scope.
// ============================================================================
`ifndef TILED_YUV_TO_RGB_PIXEL_FETCH_DEFINES_SVH
`define TILED_YUV_TO_RGB_PIXEL_FETCH_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define TYRPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define TYRPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequence after the delay n from its cause
`define TYRPF_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> rtl/tyrpf_pkg.sv
// ============================================================================
// Tiled YUV to RGB pixel fetch - package
// Word types, command struct and register codes shared by the non-RAM modules.
// ============================================================================
package tyrpf_pkg;

    // Field widths fixed by the interface
    localparam int LOAD_ADDR_W = 20;
    localparam int COORD_W     = 10;
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    // Input word kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RGB_ORDER    = 2'd2;

    // Configuration reset values
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 10'd720;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 10'd576;
    localparam logic               RGB_ORDER_RST    = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [BYTE_W-1:0]      load_data;
        logic [COORD_W-1:0]     column;
        logic [COORD_W-1:0]     line;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] first_channel;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] last_channel;
        logic              out_of_range;
    } t_out_word;

    // Controller to datapath commands, at most one active per cycle
    typedef struct packed {
        logic capture;   // latch convert coordinate
        logic write;     // store one load byte
        logic addr;      // register tiled addresses
        logic read;      // read luma and chroma pair
        logic load_out;  // load result into output register
    } t_dp_cmd;

endpackage

>>> rtl/tyrpf_ram.sv
// ============================================================================
// Tiled YUV to RGB pixel fetch - generic RAM
// One write port, two read ports with registered read data.
// ============================================================================
module tyrpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read two entries, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

>>> rtl/tyrpf_ctrl.sv
// ============================================================================
// Tiled YUV to RGB pixel fetch - controller
// Sequences each convert word through address, read and colour stages.
// ============================================================================
`include "tiled_yuv_to_rgb_pixel_fetch_defines.svh"

module tyrpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output tyrpf_pkg::t_dp_cmd o_cmd
);
    import tyrpf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_CALC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    // Take a word only between converts
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Decode commands from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = w_accept && (i_in_kind == KIND_CONVERT);
        o_cmd.write    = w_accept && (i_in_kind == KIND_LOAD);
        o_cmd.addr     = (r_state == S_ADDR);
        o_cmd.read     = (r_state == S_READ);
        o_cmd.load_out = (r_state == S_CALC) && w_out_free;
    end

    // Advance state, track output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Checks on sequencing
    `TYRPF_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(o_cmd), "more than one datapath command")
    `TYRPF_ASSERT_DELAY(a_convert_reaches_calc, o_cmd.capture, 3, r_state == S_CALC, "convert did not reach colour stage")
    `TYRPF_ASSERT_NEXT(a_result_published, o_cmd.load_out, r_out_valid && (r_state == S_IDLE), "result not published")

endmodule

>>> rtl/tyrpf_dp.sv
// ============================================================================
// Tiled YUV to RGB pixel fetch - datapath
// Config registers, two byte-interleaved frame banks, address and colour math.
// ============================================================================
module tyrpf_dp #(
    parameter int LINE_STRIDE = 720,
    parameter int MAX_LINES   = 576
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tyrpf_pkg::t_dp_cmd                    i_cmd,
    input  tyrpf_pkg::t_in_word                   i_in,
    input  logic                                  i_cfg_we,
    input  logic [tyrpf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tyrpf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output tyrpf_pkg::t_out_word                  o_out
);
    import tyrpf_pkg::*;

    localparam int STORE_DEPTH = LINE_STRIDE * MAX_LINES * 3 / 2;
    localparam int BANK_DEPTH  = (STORE_DEPTH + 1) / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int BPR         = LINE_STRIDE / 16;
    localparam int CALC_W      = $clog2(LINE_STRIDE * 2048 + 256);
    localparam int ADDR_W      = (CALC_W > LOAD_ADDR_W) ? CALC_W : LOAD_ADDR_W;

    // Clamp a signed sum to one byte
    function automatic logic [BYTE_W-1:0] clamp8(input logic signed [11:0] v);
        logic [BYTE_W-1:0] res;
        if (v < 12'sd0) begin
            res = '0;
        end else if (v > 12'sd255) begin
            res = 8'hff;
        end else begin
            res = v[BYTE_W-1:0];
        end
        return res;
    endfunction

    logic [COORD_W-1:0] r_frame_width;
    logic [COORD_W-1:0] r_frame_height;
    logic               r_rgb_order;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_rgb_order    <= RGB_ORDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[COORD_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[COORD_W-1:0];
                CFG_RGB_ORDER:    r_rgb_order    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Latch convert coordinate
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_in.column;
            r_row <= i_in.line;
        end
    end

    // Load path: drop writes beyond the store, even bytes to bank 0
    logic [ADDR_W-1:0]  w_load_addr;
    logic               w_load_ok;
    logic               w_we0;
    logic               w_we1;
    logic [BANK_AW-1:0] w_load_idx;

    assign w_load_addr = ADDR_W'(i_in.load_address);
    assign w_load_ok   = w_load_addr < ADDR_W'(STORE_DEPTH);
    assign w_we0       = i_cmd.write && w_load_ok && !w_load_addr[0];
    assign w_we1       = i_cmd.write && w_load_ok && w_load_addr[0];
    assign w_load_idx  = w_load_addr[BANK_AW:1];

    // Tiled luma and chroma addresses
    logic [ADDR_W-1:0] w_lum_blk;
    logic [ADDR_W-1:0] w_lum_addr;
    logic [ADDR_W-1:0] w_chr_blk;
    logic [ADDR_W-1:0] w_chr_base;
    logic [ADDR_W-1:0] w_chr_addr;
    logic              w_oor;

    assign w_lum_blk  = ADDR_W'(r_row[9:4]) * ADDR_W'(BPR) + ADDR_W'(r_col[9:4]);
    assign w_lum_addr = (w_lum_blk << 8) | ADDR_W'({r_row[3:0], r_col[3:0]});
    assign w_chr_blk  = ADDR_W'(r_row[9:5]) * ADDR_W'(BPR) + ADDR_W'(r_col[9:4]);
    assign w_chr_base = ADDR_W'(LINE_STRIDE) * ADDR_W'(r_frame_height);
    assign w_chr_addr = w_chr_base + (w_chr_blk << 8)
                      + ADDR_W'({r_row[4], r_row[3:1], r_col[3:1], 1'b0});
    assign w_oor      = (r_col >= r_frame_width) || (r_row >= r_frame_height);

    logic               r_oor;
    logic [BANK_AW-1:0] r_lum_idx;
    logic               r_lum_odd;
    logic               r_lum_oob;
    logic [BANK_AW-1:0] r_chr_idx;
    logic               r_chr_oob;

    // Register addresses; chroma pair is always even so one index covers both
    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_oor     <= w_oor;
            r_lum_idx <= w_lum_addr[BANK_AW:1];
            r_lum_odd <= w_lum_addr[0];
            r_lum_oob <= w_lum_addr >= ADDR_W'(STORE_DEPTH);
            r_chr_idx <= w_chr_addr[BANK_AW:1];
            r_chr_oob <= w_chr_addr >= ADDR_W'(STORE_DEPTH);
        end
    end

    // Frame banks: port a reads luma, port b reads the chroma pair
    logic [BYTE_W-1:0] w_b0_a;
    logic [BYTE_W-1:0] w_b0_b;
    logic [BYTE_W-1:0] w_b1_a;
    logic [BYTE_W-1:0] w_b1_b;

    tyrpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .i_clk       (i_clk),
        .i_wr_en     (w_we0),
        .i_wr_addr   (w_load_idx),
        .i_wr_data   (i_in.load_data),
        .i_rd_en     (i_cmd.read),
        .i_rd_addr_a (r_lum_idx),
        .i_rd_addr_b (r_chr_idx),
        .o_rd_data_a (w_b0_a),
        .o_rd_data_b (w_b0_b)
    );

    tyrpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .i_clk       (i_clk),
        .i_wr_en     (w_we1),
        .i_wr_addr   (w_load_idx),
        .i_wr_data   (i_in.load_data),
        .i_rd_en     (i_cmd.read),
        .i_rd_addr_a (r_lum_idx),
        .i_rd_addr_b (r_chr_idx),
        .o_rd_data_a (w_b1_a),
        .o_rd_data_b (w_b1_b)
    );

    // Select bytes, reads past the store give zero
    logic [BYTE_W-1:0] w_y;
    logic [BYTE_W-1:0] w_u;
    logic [BYTE_W-1:0] w_v;

    assign w_y = r_lum_oob ? '0 : (r_lum_odd ? w_b1_a : w_b0_a);
    assign w_u = r_chr_oob ? '0 : w_b0_b;
    assign w_v = r_chr_oob ? '0 : w_b1_b;

    // Shift-add colour conversion with floor shifts
    logic signed [8:0]  w_du;
    logic signed [8:0]  w_dv;
    logic signed [15:0] w_u129;
    logic signed [12:0] w_rg_sum;
    logic signed [10:0] w_v3;
    logic signed [11:0] w_u1;
    logic signed [11:0] w_rg;
    logic signed [11:0] w_v1;
    logic signed [11:0] w_ys;
    logic [BYTE_W-1:0]  w_red;
    logic [BYTE_W-1:0]  w_grn;
    logic [BYTE_W-1:0]  w_blu;

    assign w_du     = $signed({1'b0, w_u}) - 9'sd128;
    assign w_dv     = $signed({1'b0, w_v}) - 9'sd128;
    assign w_u129   = (16'(w_du) <<< 7) + 16'(w_du);
    assign w_rg_sum = (13'(w_du) <<< 1) + 13'(w_du) + (13'(w_dv) <<< 2) + (13'(w_dv) <<< 1);
    assign w_v3     = (11'(w_dv) <<< 1) + 11'(w_dv);
    assign w_u1     = 12'(w_u129 >>> 6);
    assign w_rg     = 12'(w_rg_sum >>> 3);
    assign w_v1     = 12'(w_v3 >>> 1);
    assign w_ys     = $signed({4'b0000, w_y});
    assign w_red    = clamp8(w_ys + w_v1);
    assign w_grn    = clamp8(w_ys - w_rg);
    assign w_blu    = clamp8(w_ys + w_u1);

    t_out_word r_out;

    // Load output register, zeros and flag for a pixel outside the frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_oor) begin
                r_out <= '{first_channel: '0, green: '0, last_channel: '0,
                           out_of_range: 1'b1};
            end else begin
                r_out.first_channel <= r_rgb_order ? w_red : w_blu;
                r_out.green         <= w_grn;
                r_out.last_channel  <= r_rgb_order ? w_blu : w_red;
                r_out.out_of_range  <= 1'b0;
            end
        end
    end

    assign o_out = r_out;

endmodule

>>> rtl/tiled_yuv_to_rgb_pixel_fetch.sv
// ============================================================================
// Load word: stores one byte. Convert word: the address, dual-bank RAM read and
// colour stages run in turn; the result is loaded into an output register and
// parked there until taken, while the next word is accepted.
// Sync active-low reset clears control and config; the frame RAM is not cleared.
// ============================================================================
module tiled_yuv_to_rgb_pixel_fetch #(
    parameter int LINE_STRIDE = 720,
    parameter int MAX_LINES   = 576
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tyrpf_pkg::t_in_word               i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tyrpf_pkg::t_out_word              o_out,
    input  logic                              i_cfg_we,
    input  logic [tyrpf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tyrpf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tyrpf_pkg::*;

    t_dp_cmd w_cmd;

    // Sequence words
    tyrpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in.kind),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Store frame, fetch and convert pixels
    tyrpf_dp #(
        .LINE_STRIDE (LINE_STRIDE),
        .MAX_LINES   (MAX_LINES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule
